>>> design/bdq_pkg.sv
// bdq_pkg: shared types, constants and pointer helpers for the bounded deque.
// No dependencies; imported by every module of the block.
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int FUNC_W = 3;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_EMPTY = '0;

    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;

    // Operation codes carried by the func field; unlisted codes act as peek.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_PEEK       = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Request from the controller to the slot memory.
    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_word wdata;
        logic  re;
        t_ptr  raddr_front;
        t_ptr  raddr_rear;
    } t_mem_req;

    // Result bookkeeping handed to the output register.
    typedef struct packed {
        logic load;
        t_cnt count;
        logic drop;
    } t_res_info;

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == PTR_LAST) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        return (p == '0) ? PTR_LAST : p - t_ptr'(1);
    endfunction

endpackage

>>> design/bdq_mem.sv
// bdq_mem: slot storage of the deque, one write port and two registered read ports.
// Depends on bdq_pkg.
module bdq_mem
    import bdq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rd_front,
    output t_word    o_rd_rear
);

    t_word r_slots [DEPTH];
    t_word r_rd_front;
    t_word r_rd_rear;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_slots[i_req.waddr] <= i_req.wdata;
        end
    end

    // Hold read data until the next read request.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_front <= r_slots[i_req.raddr_front];
            r_rd_rear  <= r_slots[i_req.raddr_rear];
        end
    end

    assign o_rd_front = r_rd_front;
    assign o_rd_rear  = r_rd_rear;

endmodule

>>> design/bdq_ctrl.sv
// bdq_ctrl: sequencer, head/tail pointers and count of the deque.
// Depends on bdq_pkg; drives bdq_mem and the output register in the top level.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [FUNC_W-1:0]    i_func,
    input  t_word                i_value,
    input  logic                 i_out_free,
    output logic                 o_in_stall,
    output t_mem_req             o_mem_req,
    output t_res_info            o_info
);

    t_state r_state, n_state;
    t_ptr   r_head, n_head;
    t_ptr   r_tail, n_tail;
    t_cnt   r_count, n_count;
    logic   r_drop, n_drop;

    logic accept;
    logic full;
    logic empty;
    logic push_we;
    t_ptr push_addr;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign full   = (r_count >= CNT_FULL);
    assign empty  = (r_count == CNT_EMPTY);

    // Apply the operation to pointers and count.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_drop    = r_drop;
        push_we   = 1'b0;
        push_addr = r_tail;
        if (accept) begin
            n_drop = 1'b0;
            case (i_func)
                FN_PUSH_FRONT: begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_head    = ptr_dec(r_head);
                        push_addr = n_head;
                        push_we   = 1'b1;
                        n_count   = r_count + t_cnt'(1);
                    end
                end
                FN_PUSH_REAR: begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        push_addr = r_tail;
                        push_we   = 1'b1;
                        n_tail    = ptr_inc(r_tail);
                        n_count   = r_count + t_cnt'(1);
                    end
                end
                FN_POP_FRONT: begin
                    if (!empty) begin
                        n_head  = ptr_inc(r_head);
                        n_count = r_count - t_cnt'(1);
                    end
                end
                FN_POP_REAR: begin
                    if (!empty) begin
                        n_tail  = ptr_dec(r_tail);
                        n_count = r_count - t_cnt'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept)     n_state = ST_READ;
            ST_READ:                 n_state = ST_LOAD;
            ST_LOAD: if (i_out_free) n_state = ST_IDLE;
            default:                 n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall            = 1'b1;
        o_mem_req.we          = push_we;
        o_mem_req.waddr       = push_addr;
        o_mem_req.wdata       = i_value;
        o_mem_req.re          = 1'b0;
        o_mem_req.raddr_front = r_head;
        o_mem_req.raddr_rear  = ptr_dec(r_tail);
        o_info.load           = 1'b0;
        o_info.count          = r_count;
        o_info.drop           = r_drop;
        unique case (r_state)
            ST_IDLE: o_in_stall   = 1'b0;
            ST_READ: o_mem_req.re = 1'b1;
            ST_LOAD: o_info.load  = i_out_free;
            default: o_in_stall   = 1'b1;
        endcase
    end

endmodule

>>> design/bounded_deque.sv
// bounded_deque: top level of a bounded double-ended queue of signed words.
// Depends on bdq_pkg, bdq_ctrl and bdq_mem.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------------
//   input   | i_in_valid / o_in_stall    | i_func, i_value
//   output  | o_out_valid / i_out_stall  | o_front_value, o_rear_value, o_occupancy,
//           |                            | o_is_empty, o_is_full, o_dropped
//
// For each item, the accept step updates pointers and count and writes a
// pushed word, the read step reads front and rear from the slot memory, and
// the load step loads the output register once that register is free. There
// is a single memory read stage. Reset clears pointers, count and the
// sequencer; slot contents are unknown until written and are never shown before that.
// The output register holds a result under stall while the next item is
// accepted; the sequencer waits in its load step until that register frees.
module bounded_deque
    import bdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  t_word             i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_word             o_front_value,
    output t_word             o_rear_value,
    output t_cnt              o_occupancy,
    output logic              o_is_empty,
    output logic              o_is_full,
    output logic              o_dropped
);

    t_mem_req  mem_req;
    t_res_info info;
    t_word     rd_front;
    t_word     rd_rear;
    logic      out_free;

    logic  r_out_valid;
    t_word r_front;
    t_word r_rear;
    t_cnt  r_occ;
    logic  r_empty;
    logic  r_full;
    logic  r_drop;

    logic  res_empty;

    // The output register is free when empty or being taken this cycle.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign res_empty = (info.count == CNT_EMPTY);

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_mem_req  (mem_req),
        .o_info     (info)
    );

    bdq_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_front (rd_front),
        .o_rd_rear  (rd_rear)
    );

    // Track valid: set on load, drop when the consumer takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (info.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the payload; an empty deque shows all ones on both ends.
    always_ff @(posedge i_clk) begin
        if (info.load) begin
            r_front <= res_empty ? '1 : rd_front;
            r_rear  <= res_empty ? '1 : rd_rear;
            r_occ   <= info.count;
            r_empty <= res_empty;
            r_full  <= (info.count >= CNT_FULL);
            r_drop  <= info.drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_rear_value  = r_rear;
    assign o_occupancy   = r_occ;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_dropped     = r_drop;

endmodule

>>> tb/deque_checker.sv
// deque_checker: watches both channels of bounded_deque, predicts every result
// and compares it field by field. Depends on bdq_pkg only.
module deque_checker
    import bdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  t_word             i_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_word             i_front_value,
    input  t_word             i_rear_value,
    input  t_cnt              i_occupancy,
    input  logic              i_is_empty,
    input  logic              i_is_full,
    input  logic              i_dropped,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_refused
);

    localparam t_word EMPTY_WORD = -1;

    typedef struct {
        t_word front;
        t_word rear;
        t_cnt  occ;
        logic  empty;
        logic  full;
        logic  drop;
    } t_deque_view;

    // Shadow copy of the ring
    t_word       slot_mem [DEPTH];
    int          front_idx;
    int          back_idx;
    int          held_words;
    t_deque_view expected_q [$];
    int          fail_total;
    int          checked_total;
    int          refused_total;

    function automatic t_deque_view apply_deque_op(input logic [FUNC_W-1:0] op,
                                                   input t_word word);
        t_deque_view view;
        logic        was_full;
        was_full  = (held_words >= DEPTH);
        view.drop = 1'b0;
        case (op)
            FN_PUSH_FRONT: begin
                if (was_full) begin
                    view.drop = 1'b1;
                end else begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    slot_mem[front_idx] = word;
                    held_words++;
                end
            end
            FN_PUSH_REAR: begin
                if (was_full) begin
                    view.drop = 1'b1;
                end else begin
                    slot_mem[back_idx] = word;
                    back_idx = (back_idx + 1) % DEPTH;
                    held_words++;
                end
            end
            FN_POP_FRONT: begin
                if (held_words != 0) begin
                    front_idx = (front_idx + 1) % DEPTH;
                    held_words--;
                end
            end
            FN_POP_REAR: begin
                if (held_words != 0) begin
                    back_idx = (back_idx + DEPTH - 1) % DEPTH;
                    held_words--;
                end
            end
            default: begin
            end
        endcase
        if (held_words != 0) begin
            view.front = slot_mem[front_idx];
            view.rear  = slot_mem[(back_idx + DEPTH - 1) % DEPTH];
        end else begin
            view.front = EMPTY_WORD;
            view.rear  = EMPTY_WORD;
        end
        view.occ   = t_cnt'(held_words);
        view.empty = (held_words == 0);
        view.full  = (held_words >= DEPTH);
        return view;
    endfunction

    always @(posedge i_clk) begin
        t_deque_view want;
        if (!i_rst_n) begin
            front_idx     = 0;
            back_idx      = 0;
            held_words    = 0;
            fail_total    = 0;
            checked_total = 0;
            refused_total = 0;
            expected_q.delete();
        end else begin
            // Check the result leaving this cycle before predicting the new item
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("checker: unexpected result: front %0d rear %0d occ %0d",
                                 i_front_value, i_rear_value, i_occupancy);
                end else begin
                    want = expected_q.pop_front();
                    checked_total++;
                    if (i_dropped === 1'b1)
                        refused_total++;
                    if (i_front_value !== want.front || i_rear_value !== want.rear ||
                        i_occupancy !== want.occ || i_is_empty !== want.empty ||
                        i_is_full !== want.full || i_dropped !== want.drop) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("checker: mismatch on result %0d", checked_total);
                            $display(
                                "  expected front %0d rear %0d occ %0d empty %b full %b drop %b",
                                want.front, want.rear, want.occ, want.empty, want.full,
                                want.drop);
                            $display(
                                "  actual   front %0d rear %0d occ %0d empty %b full %b drop %b",
                                i_front_value, i_rear_value, i_occupancy, i_is_empty,
                                i_is_full, i_dropped);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(apply_deque_op(i_func, i_value));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_q.size();
        o_checked    <= checked_total;
        o_refused    <= refused_total;
    end

endmodule

>>> tb/testbench.sv
// testbench: drives bounded_deque with directed and random deque operations
// and leaves all checking to deque_checker. Depends on bdq_pkg and both modules.
module testbench;
    import bdq_pkg::*;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [FUNC_W-1:0] i_func      = FN_PEEK;
    t_word             i_value     = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_word             o_front_value;
    t_word             o_rear_value;
    t_cnt              o_occupancy;
    logic              o_is_empty;
    logic              o_is_full;
    logic              o_dropped;

    int fail_count;
    int pending;
    int checked;
    int refused;

    // Sender pacing and bookkeeping
    int burst_left;
    int items_sent;
    int push_sent;
    int pop_sent;
    int peek_sent;

    // Receiver stall pattern
    int stall_left;
    int stall_mode;

    bounded_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_dropped     (o_dropped)
    );

    deque_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_front_value (o_front_value),
        .i_rear_value  (o_rear_value),
        .i_occupancy   (o_occupancy),
        .i_is_empty    (o_is_empty),
        .i_is_full     (o_is_full),
        .i_dropped     (o_dropped),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_refused     (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run well past the slowest legal pace
    initial begin
        #5000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Stall the result channel in stretches: free-running, random, or solid
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 9);
            stall_left = (stall_mode == 9) ? $urandom_range(10, 30) : $urandom_range(5, 40);
        end else begin
            stall_left--;
        end
        if (!i_rst_n || stall_mode < 4)
            i_out_stall <= 1'b0;
        else if (stall_mode < 9)
            i_out_stall <= ($urandom_range(0, 1) == 1);
        else
            i_out_stall <= 1'b1;
    end

    // Present one item and hold it until accepted, then pace the next one.
    // Keep valid high across a burst; drop it only when a gap follows.
    task automatic send_item(input logic [FUNC_W-1:0] op, input t_word word);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_value    <= word;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        case (op) inside
            FN_PUSH_FRONT, FN_PUSH_REAR: push_sent++;
            FN_POP_FRONT, FN_POP_REAR:   pop_sent++;
            default:                     peek_sent++;
        endcase
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            // Mostly short gaps, now and then a long one
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // Long bursts give stretches with no sender idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    initial begin
        logic              fill_phase;
        int                phase_left;
        int                pick;
        logic [FUNC_W-1:0] op;
        t_word             word;

        burst_left = 3;
        stall_left = 0;
        stall_mode = 0;
        items_sent = 0;
        push_sent  = 0;
        pop_sent   = 0;
        peek_sent  = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operations on an empty deque
        send_item(FN_PEEK, 32'sh1234_5678);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_POP_REAR, '1);
        // Extreme words at each end
        send_item(FN_PUSH_FRONT, 32'sh8000_0000);
        send_item(FN_PUSH_REAR, 32'sh7FFF_FFFF);
        // Fill to capacity from both ends so the pointers wrap
        for (int k = 2; k < DEPTH; k++)
            send_item((k % 2 == 0) ? FN_PUSH_FRONT : FN_PUSH_REAR,
                      t_word'(32'hA5A5_0000 | k));
        // Pushes on a full deque are refused
        send_item(FN_PUSH_FRONT, 32'sh0BAD_0001);
        send_item(FN_PUSH_REAR, 32'sh0BAD_0002);
        // Spare codes act as a plain peek
        for (int c = FN_PEEK + 1; c < (1 << FUNC_W); c++)
            send_item(FUNC_W'(c), $urandom);

        // Random: alternate fill-biased and drain-biased phases so the
        // occupancy swings between empty and full many times
        fill_phase = 1'b0;
        phase_left = 0;
        for (int n = 0; n < 1350; n++) begin
            if (phase_left == 0) begin
                fill_phase = ~fill_phase;
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < (fill_phase ? 60 : 25))
                op = $urandom_range(0, 1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
            else if (pick < 85)
                op = $urandom_range(0, 1) ? FN_POP_REAR : FN_POP_FRONT;
            else if (pick < 95)
                op = FN_PEEK;
            else
                op = FUNC_W'($urandom_range(FN_PEEK + 1, (1 << FUNC_W) - 1));
            case ($urandom_range(0, 7))
                0:       word = 32'sh8000_0000;
                1:       word = 32'sh7FFF_FFFF;
                2:       word = -1;
                3:       word = '0;
                4:       word = t_word'($urandom_range(0, 255));
                default: word = $urandom;
            endcase
            send_item(op, word);
        end

        // Drain: wait until every expected result has arrived, then settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("summary: %0d items sent (%0d pushes, %0d pops, %0d peeks incl. spare codes)",
                 items_sent, push_sent, pop_sent, peek_sent);
        $display("summary: %0d results checked, %0d refused pushes, %0d failures",
                 checked, refused, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
